@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL; they expand to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Hold cons in the same cycle whenever ante is true.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Hold cons in the cycle after ante is true.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ src/fmpd_pkg.sv @@
// Shared constants, command types and modular helpers for the Fibonacci doubling block.
package fmpd_pkg;

  localparam int LENGTH_W    = 63;
  localparam int COUNT_W     = 30;
  localparam int LENGTH_BITS = 63;
  localparam int M_W         = LENGTH_BITS + 1;
  localparam int STEP_W      = $clog2(M_W);
  localparam int PROD_W      = 2 * COUNT_W;
  localparam int BAR_W       = COUNT_W + 1;
  localparam int RED_W       = COUNT_W + 2;
  localparam int PH_W        = 3;

  localparam logic [COUNT_W-1:0] PRIME  = 30'd1000000007;
  localparam logic [RED_W-1:0]   PRIME1 = RED_W'(PRIME);
  localparam logic [RED_W-1:0]   PRIME2 = RED_W'(2 * 64'(PRIME));
  // Barrett constant floor(2^60 / P)
  localparam logic [BAR_W-1:0]   MU     = BAR_W'((64'd1 << PROD_W) / 64'(PRIME));

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(M_W - 1);

  // Phases of one doubling step
  localparam logic [PH_W-1:0] PH_SQ_A    = 3'd0;
  localparam logic [PH_W-1:0] PH_SQ_B    = 3'd1;
  localparam logic [PH_W-1:0] PH_MUL_T   = 3'd2;
  localparam logic [PH_W-1:0] PH_CAP_SQ  = 3'd4;
  localparam logic [PH_W-1:0] PH_ODD     = 3'd5;
  localparam logic [PH_W-1:0] PH_ADVANCE = 3'd6;

  typedef enum logic [1:0] {
    OP_SQ_A,
    OP_SQ_B,
    OP_A_TWICE
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
    logic cap_sq;
    logic make_odd;
    logic advance;
    logic publish;
  } cmd_t;

  // Reduce a value below 3P into 0..P-1.
  function automatic logic [COUNT_W-1:0] fold3(input logic [RED_W-1:0] r);
    logic [RED_W-1:0] s;
    if (r >= PRIME2) begin
      s = r - PRIME2;
    end else if (r >= PRIME1) begin
      s = r - PRIME1;
    end else begin
      s = r;
    end
    return s[COUNT_W-1:0];
  endfunction

  // Sum of two residues, reduced once.
  function automatic logic [COUNT_W-1:0] mod_add(input logic [COUNT_W-1:0] x,
                                                 input logic [COUNT_W-1:0] y);
    return fold3(RED_W'(x) + RED_W'(y));
  endfunction

endpackage

@@ src/fmpd_modmul.sv @@
// Four-stage pipelined modular multiplier with Barrett reduction.
module fmpd_modmul import fmpd_pkg::*; (
  input  logic               clk,
  input  logic [COUNT_W-1:0] x,
  input  logic [COUNT_W-1:0] y,
  output logic [COUNT_W-1:0] prod
);

  logic [PROD_W-1:0]  p1;
  logic [2*BAR_W-1:0] t2;
  logic [RED_W-1:0]   lo2;
  logic [RED_W-1:0]   lo3;
  logic [RED_W-1:0]   qp3;

  always_ff @(posedge clk) begin
    p1   <= PROD_W'(x) * PROD_W'(y);
    // estimate quotient from the top bits
    t2   <= (2*BAR_W)'(p1[PROD_W-1:COUNT_W-1]) * (2*BAR_W)'(MU);
    lo2  <= p1[RED_W-1:0];
    // low word of quotient times P is enough: remainder stays below 3P
    qp3  <= RED_W'(t2[2*BAR_W-1:BAR_W]) * PRIME1;
    lo3  <= lo2;
    prod <= fold3(lo3 - qp3);
  end

endmodule

@@ src/fmpd_datapath.sv @@
// Datapath: Fibonacci pair registers, bit walk of n+1 and the shared modular multiplier.
module fmpd_datapath import fmpd_pkg::*; (
  input  logic                clk,
  input  cmd_t                cmd,
  input  logic [LENGTH_W-1:0] length,
  output logic [COUNT_W-1:0]  count
);

  logic [COUNT_W-1:0]     a;
  logic [COUNT_W-1:0]     b;
  logic [COUNT_W-1:0]     twice;
  logic [COUNT_W-1:0]     sq;
  logic [COUNT_W-1:0]     odd;
  logic [M_W-1:0]         m;
  logic                   special;
  logic [COUNT_W-1:0]     mm_x;
  logic [COUNT_W-1:0]     mm_y;
  logic [COUNT_W-1:0]     mm_out;
  logic [COUNT_W-1:0]     sum;
  logic [LENGTH_BITS-1:0] n;

  assign n   = length[LENGTH_BITS-1:0];
  assign sum = mod_add(mm_out, odd);

  always_comb begin
    case (cmd.op)
      OP_SQ_A: begin
        mm_x = a;
        mm_y = a;
      end
      OP_SQ_B: begin
        mm_x = b;
        mm_y = b;
      end
      default: begin
        mm_x = a;
        mm_y = twice;
      end
    endcase
  end

  fmpd_modmul u_modmul (
    .clk  (clk),
    .x    (mm_x),
    .y    (mm_y),
    .prod (mm_out)
  );

  always_ff @(posedge clk) begin
    // 2*F(k+1) - F(k), kept in range
    twice <= fold3((RED_W'(b) << 1) + PRIME1 - RED_W'(a));
    if (cmd.load) begin
      a       <= '0;
      b       <= COUNT_W'(1);
      m       <= M_W'(n) + M_W'(1);
      special <= (n == LENGTH_BITS'(1));
    end
    if (cmd.cap_sq) begin
      sq <= mm_out;
    end
    if (cmd.make_odd) begin
      odd <= mod_add(sq, mm_out);
    end
    if (cmd.advance) begin
      if (m[M_W-1]) begin
        a <= odd;
        b <= sum;
      end else begin
        a <= mm_out;
        b <= odd;
      end
      m <= m << 1;
    end
    if (cmd.publish) begin
      count <= special ? COUNT_W'(1) : b;
    end
  end

endmodule

@@ src/fmpd_ctrl.sv @@
// Controller: sequences doubling steps and owns the handshake state.
module fmpd_ctrl import fmpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic out_stall,
  output logic out_valid,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FINISH
  } state_t;

  state_t            state;
  logic [PH_W-1:0]   phase;
  logic [STEP_W-1:0] step;
  logic              accept;
  logic              out_free;
  logic              run;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign run      = (state == S_RUN);

  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.cap_sq   = run && (phase == PH_CAP_SQ);
    cmd.make_odd = run && (phase == PH_ODD);
    cmd.advance  = run && (phase == PH_ADVANCE);
    cmd.publish  = (state == S_FINISH) && out_free;
    case (phase)
      PH_SQ_A:  cmd.op = OP_SQ_A;
      PH_SQ_B:  cmd.op = OP_SQ_B;
      PH_MUL_T: cmd.op = OP_A_TWICE;
      default:  cmd.op = OP_A_TWICE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_SQ_A;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
            phase <= PH_SQ_A;
            step  <= '0;
          end
        end
        S_RUN: begin
          if (phase == PH_ADVANCE) begin
            phase <= PH_SQ_A;
            if (step == LAST_STEP) begin
              state <= S_FINISH;
            end else begin
              step <= step + STEP_W'(1);
            end
          end else begin
            phase <= phase + PH_W'(1);
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/fibonacci_mod_prime_doubling.sv @@
// A result word is loaded once all 64 doubling steps of its input word are done
// and the output slot is free; a new input word is accepted only after that.
// The block takes no new word while one is in flight; each step runs three products through the
// 4-stage shared modular multiplier, and the next step needs this step's pair.
// Reset (rst, synchronous): returns to idle and drops any pending output word.
`include "assert_macros.svh"

module fibonacci_mod_prime_doubling import fmpd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [LENGTH_W-1:0] length,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COUNT_W-1:0]  count
);

  cmd_t cmd;

  // Controller: accepts a word while idle, walks the bits of n+1 from the
  // top, and loads the output register once the slot is free. A waiting
  // result in the output register does not block the next input word.
  fmpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Datapath: holds (F(k), F(k+1)), issues a^2, b^2 and a*(2b-a) to the
  // shared multiplier, then forms the doubled pair and advances on a set bit.
  // Length one is answered with 1 directly.
  fmpd_datapath u_datapath (
    .clk    (clk),
    .cmd    (cmd),
    .length (length),
    .count  (count)
  );

  // Once a word is taken, hold off the next one until this one is done.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "accepted word did not make the block busy")

  // Every published count is a residue.
  `ASSERT_IMPL(a_count_residue, clk, rst, out_valid, count < PRIME, "count out of residue range")

  // A result appears only at the end of a computation.
  `ASSERT_IMPL(a_publish_from_run, clk, rst, $rose(out_valid), $past(in_stall), "result published while idle")

endmodule
